>>> rtl/dakf_pkg.sv
// ============================================================================
// dakf_pkg: shared types and constants for the dual-axis Kalman fusion block
// Payload structs, configuration register indexes, controller states and the
// command bundle passed from the controller to the datapath.
// ============================================================================
`default_nettype none

package dakf_pkg;

    // Default parameter values
    localparam int DEF_NUM_AXES  = 2;
    localparam int DEF_FRAC_BITS = 16;

    // Word width of positions and variances
    localparam int DATA_W = 32;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

    // Configuration reset values (unsigned Q16.16)
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd65;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd65536;

    // Input transaction payload
    typedef struct packed {
        logic                     channel;
        logic signed [DATA_W-1:0] measurement;
        logic signed [DATA_W-1:0] displacement;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic                     channel_out;
        logic signed [DATA_W-1:0] estimate;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_DEN,
        S_DIV,
        S_MULX,
        S_MULP,
        S_FIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input transaction
        logic pred;       // predict x' and p'
        logic den;        // form p'+r, innovation, divider setup
        logic div_step;   // one restoring division step
        logic div_first;  // first division step feeds p'[0]
        logic mul_x;      // multiply gain by innovation
        logic mul_p;      // multiply (one-k) by p', finish estimate
        logic finish;     // write back state, load output register
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/dakf_ctrl.sv
// ============================================================================
// dakf_ctrl: sequencing controller
// Steps one transaction through predict, divide, multiply and write-back,
// and owns the input ready and output valid handshake signals.
// ============================================================================
`default_nettype none

module dakf_ctrl #(
    parameter int FRAC_BITS = dakf_pkg::DEF_FRAC_BITS
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output dakf_pkg::t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    dakf_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // Output slot can take a new result this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dakf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            dakf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dakf_pkg::S_PRED;
                end
            end
            dakf_pkg::S_PRED: begin
                o_cmd.pred = 1'b1;
                n_state    = dakf_pkg::S_DEN;
            end
            dakf_pkg::S_DEN: begin
                o_cmd.den = 1'b1;
                n_cnt     = '0;
                n_state   = dakf_pkg::S_DIV;
            end
            dakf_pkg::S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = dakf_pkg::S_MULX;
                end
            end
            dakf_pkg::S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = dakf_pkg::S_MULP;
            end
            dakf_pkg::S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = dakf_pkg::S_FIN;
            end
            dakf_pkg::S_FIN: begin
                // hold here while the previous result is still pending
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = dakf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dakf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dakf_pkg::S_IDLE && i_in_valid) |=> (r_state == dakf_pkg::S_PRED))
        else $error("accepted transaction did not start prediction");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dakf_pkg::S_FIN && r_out_valid && !i_out_ready)
            |=> (r_state == dakf_pkg::S_FIN && r_out_valid))
        else $error("pending result would be overwritten");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dakf_pkg::S_DIV) |-> (r_cnt <= CNT_LAST))
        else $error("division step count overran");

endmodule

`default_nettype wire

>>> rtl/dakf_datapath.sv
// ============================================================================
// dakf_datapath: filter state, noise registers and arithmetic
// Per-axis estimate and variance, a restoring gain divider with one quotient
// bit per cycle, and one shared signed multiplier for both update products.
// ============================================================================
`default_nettype none

module dakf_datapath #(
    parameter int NUM_AXES  = dakf_pkg::DEF_NUM_AXES,
    parameter int FRAC_BITS = dakf_pkg::DEF_FRAC_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  dakf_pkg::t_cmd                    i_cmd,
    input  dakf_pkg::t_in                     i_in_data,
    input  wire                               i_cfg_wr_en,
    input  wire  [dakf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [dakf_pkg::DATA_W-1:0]       i_cfg_wdata,
    output dakf_pkg::t_out                    o_out_data
);

    localparam int DW     = dakf_pkg::DATA_W;
    localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int K_W    = FRAC_BITS + 1;          // gain, 0..one
    localparam int E_W    = DW + 1;                 // innovation / zero-extended p'
    localparam int P_W    = K_W + 1 + E_W;          // product width
    localparam logic [K_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration
    logic [DW-1:0] r_q, r_r;

    // Filter state per axis
    logic signed [DW-1:0] r_x [NUM_AXES];
    logic        [DW-1:0] r_p [NUM_AXES];

    // Working registers for one transaction
    logic        [AXIS_W-1:0] r_ch;
    logic signed [DW-1:0]     r_z, r_d, r_xm, r_xn;
    logic        [DW-1:0]     r_pm;
    logic        [DW:0]       r_den;
    logic                     r_den_zero;
    logic signed [E_W-1:0]    r_e;
    logic        [DW:0]       r_rem;
    logic        [K_W-1:0]    r_quo;
    logic signed [P_W-1:0]    r_prod;
    dakf_pkg::t_out           r_out;

    // Combinational helpers
    logic signed [DW:0]   xsum;
    logic signed [DW-1:0] xm_sat;
    logic        [DW:0]   psum;
    logic        [DW-1:0] pm_sat;
    logic        [DW:0]   den_sum;
    logic        [DW+1:0] trial, diff;
    logic                 ge;
    logic        [K_W-1:0] gain, mul_a;
    logic signed [E_W-1:0] mul_b;
    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] prod_sh;
    logic signed [DW+1:0]  xn_sum;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= dakf_pkg::PROCESS_NOISE_RST;
            r_r <= dakf_pkg::MEASURE_NOISE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                dakf_pkg::REG_PROCESS_NOISE: r_q <= i_cfg_wdata;
                dakf_pkg::REG_MEASURE_NOISE: r_r <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Predict: saturating x+d and p+q
    assign xsum   = {r_x[r_ch][DW-1], r_x[r_ch]} + {r_d[DW-1], r_d};
    assign xm_sat = (xsum[DW] != xsum[DW-1])
                    ? (xsum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                    : xsum[DW-1:0];
    assign psum   = {1'b0, r_p[r_ch]} + {1'b0, r_q};
    assign pm_sat = psum[DW] ? {DW{1'b1}} : psum[DW-1:0];

    // Gain denominator
    assign den_sum = {1'b0, r_pm} + {1'b0, r_r};

    // Restoring division step; first step brings in p'[0]
    assign trial = {r_rem, (i_cmd.div_first ? r_pm[0] : 1'b0)};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    // Gain is one when the denominator is zero
    assign gain = r_den_zero ? ONE : r_quo;

    // Shared multiplier: k * e, then (one - k) * p'
    assign mul_a = i_cmd.mul_p ? (ONE - gain) : gain;
    assign mul_b = i_cmd.mul_p ? $signed({1'b0, r_pm}) : r_e;
    assign prod  = $signed({1'b0, mul_a}) * mul_b;

    // Floor shift of k*e and new estimate
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign xn_sum  = {{2{r_xm[DW-1]}}, r_xm} + $signed(prod_sh[DW+1:0]);

    // Transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch <= (NUM_AXES > 1) ? AXIS_W'(i_in_data.channel) : '0;
            r_z  <= i_in_data.measurement;
            r_d  <= i_in_data.displacement;
        end
        if (i_cmd.pred) begin
            r_xm <= xm_sat;
            r_pm <= pm_sat;
        end
        if (i_cmd.den) begin
            r_den      <= den_sum;
            r_den_zero <= (den_sum == '0);
            r_e        <= {r_z[DW-1], r_z} - {r_xm[DW-1], r_xm};
            r_rem      <= {2'b00, r_pm[DW-1:1]};
            r_quo      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? diff[DW:0] : trial[DW:0];
            r_quo <= {r_quo[K_W-2:0], ge};
        end
        if (i_cmd.mul_x || i_cmd.mul_p) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_p) begin
            r_xn <= xn_sum[DW-1:0];
        end
        if (i_cmd.finish) begin
            r_out.channel_out <= r_ch[0];
            r_out.estimate    <= r_xn;
        end
    end

    // Filter state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_x[i] <= '0;
                r_p[i] <= DW'(ONE);
            end
        end else if (i_cmd.finish) begin
            r_x[r_ch] <= r_xn;
            r_p[r_ch] <= r_prod[FRAC_BITS +: DW];
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> rtl/dual_axis_kalman_fusion.sv
// ============================================================================
// dual_axis_kalman_fusion: per-axis scalar Kalman filter with control input
// Fuses a measured position with a dead-reckoning displacement, one filter
// per axis, signed Q16.16 positions and unsigned Q16.16 variances.
//
//  Port group | Direction | Handshake                     | Payload
//  -----------+-----------+-------------------------------+-----------------
//  input      | in        | i_in_valid / o_in_ready       | i_in_data (t_in)
//  output     | out       | o_out_valid / i_out_ready     | o_out_data (t_out)
//  config     | in        | i_cfg_wr_en (no wait)         | i_cfg_idx, i_cfg_wdata
//
// An accepted transaction steps through predict, denominator, division,
// both multiplies and write-back, then the block returns to idle for the
// next. The gain divider, one quotient bit per cycle, dominates that run.
// A finished result waits in the output register while the next transaction
// is accepted; write-back stalls only if that register is still full.
// Reset (synchronous, active low) clears state to estimate 0, variance one.
// ============================================================================
`default_nettype none

module dual_axis_kalman_fusion #(
    parameter int NUM_AXES  = dakf_pkg::DEF_NUM_AXES,
    parameter int FRAC_BITS = dakf_pkg::DEF_FRAC_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  dakf_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output dakf_pkg::t_out                   o_out_data,
    input  wire                              i_cfg_wr_en,
    input  wire  [dakf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [dakf_pkg::DATA_W-1:0]      i_cfg_wdata
);

    dakf_pkg::t_cmd cmd;

    // Sequencer
    dakf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Arithmetic and state
    dakf_datapath #(
        .NUM_AXES  (NUM_AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
